[hw/rtl/b64uf_pkg.sv]
`default_nettype none
package b64uf_pkg;

    localparam int unsigned MAX_HASH_LEN = 4095;
    localparam int unsigned LEN_W = 12;
    localparam int unsigned COUNT_CAP = (MAX_HASH_LEN < 4095) ? MAX_HASH_LEN : 4095;

    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_EQUAL = 8'h3D;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;

    localparam logic KIND_CHAR = 1'b0;
    localparam logic KIND_END  = 1'b1;
    localparam logic STATUS_OK  = 1'b0;
    localparam logic STATUS_ERR = 1'b1;

    typedef enum logic [2:0] {
        MODE_IDLE      = 3'd0,
        MODE_SCAN      = 3'd1,
        MODE_PEND_LF   = 3'd2,
        MODE_PEND_CR   = 3'd3,
        MODE_PEND_CRLF = 3'd4,
        MODE_SKIP_SP   = 3'd5
    } mode_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       first_byte;
        logic       last_byte;
    } in_word_t;

    typedef struct packed {
        logic             emit;
        logic             kind;
        logic [7:0]       hash_char;
        logic             status;
        logic [LEN_W-1:0] hash_length;
    } out_word_t;

    function automatic logic is_b64(input logic [7:0] c);
        return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A) ||
               (c >= 8'h30 && c <= 8'h39) || c == CH_PLUS || c == CH_SLASH ||
               c == CH_EQUAL;
    endfunction

    function automatic logic is_sp(input logic [7:0] c);
        return c == CH_SPACE || c == CH_TAB;
    endfunction

endpackage
`default_nettype wire

[hw/rtl/b64uf_in_stage.sv]
`default_nettype none
module b64uf_in_stage
    import b64uf_pkg::*;
(
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire logic     s_valid,
    output logic          s_ready,
    input  wire in_word_t s_word,
    output logic          q_valid,
    output in_word_t      q_word,
    input  wire logic     q_take
);

    logic     valid_reg;
    in_word_t word_reg;

    assign s_ready = !valid_reg || q_take;
    assign q_valid = valid_reg;
    assign q_word  = word_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_ready) begin
            valid_reg <= s_valid;
        end
        if (s_ready && s_valid) begin
            word_reg <= s_word;
        end
    end

endmodule
`default_nettype wire

[hw/rtl/b64uf_step.sv]
`default_nettype none
module b64uf_step
    import b64uf_pkg::*;
(
    input  wire mode_t            mode,
    input  wire logic [LEN_W-1:0] count,
    input  wire in_word_t         word,
    output mode_t                 mode_next,
    output logic [LEN_W-1:0]      count_next,
    output out_word_t             result
);

    localparam logic [LEN_W-1:0] CAP = LEN_W'(COUNT_CAP);

    always_comb begin
        logic [7:0] c;
        logic       last;
        logic       do_scan;
        logic       fin;
        logic       fin_status;
        logic [7:0] fin_char;
        c          = word.data_byte;
        last       = word.last_byte;
        do_scan    = 1'b0;
        fin        = 1'b0;
        fin_status = STATUS_OK;
        fin_char   = 8'h00;
        mode_next  = mode;
        count_next = count;
        result     = '0;

        if (word.first_byte) begin
            mode_next  = MODE_SCAN;
            count_next = '0;
            if (c == CH_QUOTE) begin
                fin = last;
            end else begin
                do_scan = 1'b1;
            end
        end else begin
            unique case (mode)
                MODE_SCAN: begin
                    do_scan = 1'b1;
                end
                MODE_SKIP_SP: begin
                    if (is_sp(c)) begin
                        fin = last;
                    end else begin
                        mode_next = MODE_SCAN;
                        do_scan   = 1'b1;
                    end
                end
                MODE_PEND_LF, MODE_PEND_CRLF: begin
                    if (is_sp(c)) begin
                        mode_next = MODE_SKIP_SP;
                        fin       = last;
                    end else begin
                        fin        = 1'b1;
                        fin_status = STATUS_ERR;
                    end
                end
                MODE_PEND_CR: begin
                    if (c == CH_LF && !last) begin
                        mode_next = MODE_PEND_CRLF;
                    end else begin
                        fin        = 1'b1;
                        fin_status = STATUS_ERR;
                    end
                end
                default: begin
                    mode_next = MODE_IDLE;
                end
            endcase
        end

        if (do_scan) begin
            if (is_b64(c)) begin
                if (count_next < CAP) begin
                    count_next = count_next + LEN_W'(1);
                end
                if (last) begin
                    fin      = 1'b1;
                    fin_char = c;
                end else begin
                    result.emit      = 1'b1;
                    result.kind      = KIND_CHAR;
                    result.hash_char = c;
                end
            end else if (c == CH_LF || c == CH_CR) begin
                if (last) begin
                    fin = 1'b1;
                end else begin
                    mode_next = (c == CH_LF) ? MODE_PEND_LF : MODE_PEND_CR;
                end
            end else if (c == CH_QUOTE) begin
                fin = 1'b1;
            end else begin
                fin        = 1'b1;
                fin_status = STATUS_ERR;
            end
        end

        if (fin) begin
            mode_next        = MODE_IDLE;
            result.emit      = 1'b1;
            result.kind      = KIND_END;
            result.hash_char = fin_char;
            result.status    = fin_status;
        end
        result.hash_length = count_next;
    end

endmodule
`default_nettype wire

[hw/rtl/base64_value_unfold_checker.sv]
`default_nettype none
// An accepted input word is held in the input register, and any result word it
// yields is then held in the result register. Throughput: one input word per
// cycle unless m_ready stalls; both registers decouple the channels, and the
// mode update is combinational. Reset: synchronous active-low aresetn clears the
// mode to idle, the kept count to zero and both stage valid flags.
module base64_value_unfold_checker
    import b64uf_pkg::*;
(
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             s_valid,
    output logic                  s_ready,
    input  wire logic [7:0]       s_data_byte,
    input  wire logic             s_first_byte,
    input  wire logic             s_last_byte,
    output logic                  m_valid,
    input  wire logic             m_ready,
    output logic                  m_kind,
    output logic [7:0]            m_hash_char,
    output logic                  m_status,
    output logic [LEN_W-1:0]      m_hash_length
);

    in_word_t         s_word;
    in_word_t         q_word;
    logic             q_valid;
    logic             q_take;
    mode_t            mode_reg;
    mode_t            mode_next;
    logic [LEN_W-1:0] count_reg;
    logic [LEN_W-1:0] count_next;
    out_word_t        result;
    logic             m_valid_reg;
    out_word_t        out_reg;

    assign s_word.data_byte  = s_data_byte;
    assign s_word.first_byte = s_first_byte;
    assign s_word.last_byte  = s_last_byte;

    assign q_take = q_valid && (!m_valid_reg || m_ready);

    b64uf_in_stage u_in_stage (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_word  (s_word),
        .q_valid (q_valid),
        .q_word  (q_word),
        .q_take  (q_take)
    );

    b64uf_step u_step (
        .mode       (mode_reg),
        .count      (count_reg),
        .word       (q_word),
        .mode_next  (mode_next),
        .count_next (count_next),
        .result     (result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg    <= MODE_IDLE;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (q_take) begin
                mode_reg    <= mode_next;
                count_reg   <= count_next;
                m_valid_reg <= result.emit;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
        if (q_take && result.emit) begin
            out_reg <= result;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_kind        = out_reg.kind;
    assign m_hash_char   = out_reg.hash_char;
    assign m_status      = out_reg.status;
    assign m_hash_length = out_reg.hash_length;

endmodule
`default_nettype wire

[bench/tb_top.sv]
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import b64uf_pkg::*;

    localparam int CYCLE_LIMIT    = 800000;
    localparam int DRAIN_CYCLES   = 8;
    localparam int RANDOM_ITEMS   = 1900;
    localparam int LONG_VALUE_LEN = COUNT_CAP + 5;
    localparam int MAX_REPORTS    = 100;

    typedef struct packed {
        logic             kind;
        logic [7:0]       hash_char;
        logic             status;
        logic [LEN_W-1:0] hash_length;
    } value_word_t;

    logic             aclk         = 1'b0;
    logic             aresetn      = 1'b0;
    logic             s_valid      = 1'b0;
    logic             s_ready;
    logic [7:0]       s_data_byte  = 8'h00;
    logic             s_first_byte = 1'b0;
    logic             s_last_byte  = 1'b0;
    logic             m_valid;
    logic             m_ready      = 1'b0;
    logic             m_kind;
    logic [7:0]       m_hash_char;
    logic             m_status;
    logic [LEN_W-1:0] m_hash_length;

    mode_t            unfold_mode;
    logic [LEN_W-1:0] kept_len;
    value_word_t      expected_words[$];
    in_word_t         value_bytes[$];

    int error_count = 0;
    int cycle_count = 0;
    int live_items  = 0;
    int stall_left  = 0;
    bit tx_idle_on  = 1'b1;
    bit rx_idle_on  = 1'b1;

    base64_value_unfold_checker u_top (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_data_byte   (s_data_byte),
        .s_first_byte  (s_first_byte),
        .s_last_byte   (s_last_byte),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_kind        (m_kind),
        .m_hash_char   (m_hash_char),
        .m_status      (m_status),
        .m_hash_length (m_hash_length)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    function automatic logic b64_char(input logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") ||
               (c >= "0" && c <= "9") || c == CH_PLUS || c == CH_SLASH || c == CH_EQUAL;
    endfunction

    function automatic logic blank_char(input logic [7:0] c);
        return c == CH_SPACE || c == CH_TAB;
    endfunction

    function automatic value_word_t make_word(input logic kind, input logic [7:0] ch,
                                              input logic st);
        value_word_t w;
        w.kind        = kind;
        w.hash_char   = ch;
        w.status      = st;
        w.hash_length = kept_len;
        return w;
    endfunction

    function automatic value_word_t close_value(input logic [7:0] ch, input logic st);
        unfold_mode = MODE_IDLE;
        return make_word(KIND_END, ch, st);
    endfunction

    function automatic logic scan_char(input logic [7:0] c, input logic last,
                                       output value_word_t w);
        w = '0;
        if (b64_char(c)) begin
            if (kept_len < COUNT_CAP) begin
                kept_len = kept_len + 1'b1;
            end
            if (last) begin
                w = close_value(c, STATUS_OK);
            end else begin
                w = make_word(KIND_CHAR, c, STATUS_OK);
            end
            return 1'b1;
        end
        if (c == CH_LF || c == CH_CR) begin
            if (last) begin
                w = close_value(8'h00, STATUS_OK);
                return 1'b1;
            end
            unfold_mode = (c == CH_LF) ? MODE_PEND_LF : MODE_PEND_CR;
            return 1'b0;
        end
        w = close_value(8'h00, (c == CH_QUOTE) ? STATUS_OK : STATUS_ERR);
        return 1'b1;
    endfunction

    function automatic logic predict_word(input logic [7:0] c, input logic first,
                                          input logic last, output value_word_t w);
        w = '0;
        if (first) begin
            unfold_mode = MODE_SCAN;
            kept_len = '0;
            if (c == CH_QUOTE) begin
                if (last) begin
                    w = close_value(8'h00, STATUS_OK);
                    return 1'b1;
                end
                return 1'b0;
            end
            return scan_char(c, last, w);
        end
        case (unfold_mode)
            MODE_SCAN: begin
                return scan_char(c, last, w);
            end
            MODE_SKIP_SP: begin
                if (blank_char(c)) begin
                    if (last) begin
                        w = close_value(8'h00, STATUS_OK);
                        return 1'b1;
                    end
                    return 1'b0;
                end
                unfold_mode = MODE_SCAN;
                return scan_char(c, last, w);
            end
            MODE_PEND_LF, MODE_PEND_CRLF: begin
                if (blank_char(c)) begin
                    unfold_mode = MODE_SKIP_SP;
                    if (last) begin
                        w = close_value(8'h00, STATUS_OK);
                        return 1'b1;
                    end
                    return 1'b0;
                end
                w = close_value(8'h00, STATUS_ERR);
                return 1'b1;
            end
            MODE_PEND_CR: begin
                if (c == CH_LF && !last) begin
                    unfold_mode = MODE_PEND_CRLF;
                    return 1'b0;
                end
                w = close_value(8'h00, STATUS_ERR);
                return 1'b1;
            end
            default: begin
                unfold_mode = MODE_IDLE;
                return 1'b0;
            end
        endcase
    endfunction

    function automatic int pick_gap(input bit idle_on);
        int r;
        if (!idle_on) begin
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 60) begin
            return 0;
        end
        if (r < 93) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [7:0] b64_pick();
        int idx;
        idx = $urandom_range(0, 64);
        if (idx < 26) begin
            return 8'("A" + idx);
        end
        if (idx < 52) begin
            return 8'("a" + idx - 26);
        end
        if (idx < 62) begin
            return 8'("0" + idx - 52);
        end
        if (idx == 62) begin
            return CH_PLUS;
        end
        return (idx == 63) ? CH_SLASH : CH_EQUAL;
    endfunction

    function automatic logic [7:0] blank_pick();
        return ($urandom_range(0, 1) == 0) ? CH_SPACE : CH_TAB;
    endfunction

    function automatic in_word_t make_in(input logic [7:0] c);
        in_word_t iw;
        iw.data_byte  = c;
        iw.first_byte = 1'b0;
        iw.last_byte  = 1'b0;
        return iw;
    endfunction

    task automatic report_mismatch(input string msg);
        if (error_count < MAX_REPORTS) begin
            $display("[%0t] mismatch: %s", $time, msg);
        end
        error_count++;
    endtask

    task automatic send_word(input logic [7:0] data, input logic first, input logic last);
        int gap_len;
        value_word_t w;
        gap_len = pick_gap(tx_idle_on);
        if (gap_len > 0) begin
            s_valid <= 1'b0;
            repeat (gap_len) @(posedge aclk);
        end
        s_valid      <= 1'b1;
        s_data_byte  <= data;
        s_first_byte <= first;
        s_last_byte  <= last;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        if (first || unfold_mode != MODE_IDLE) begin
            live_items++;
        end
        if (predict_word(data, first, last, w)) begin
            expected_words.push_back(w);
        end
    endtask

    task automatic add_byte(input logic [7:0] c);
        value_bytes.push_back(make_in(c));
    endtask

    task automatic build_value();
        int body_len;
        value_bytes.delete();
        body_len = ($urandom_range(0, 19) == 0) ? $urandom_range(13, 120) : $urandom_range(0, 12);
        if ($urandom_range(0, 3) == 0) begin
            add_byte(CH_QUOTE);
        end
        repeat (body_len) begin
            case ($urandom_range(0, 19))
                0: begin
                    add_byte(CH_LF);
                    repeat ($urandom_range(1, 3)) add_byte(blank_pick());
                end
                1: begin
                    add_byte(CH_CR);
                    add_byte(CH_LF);
                    repeat ($urandom_range(1, 3)) add_byte(blank_pick());
                end
                default: add_byte(b64_pick());
            endcase
        end
        case ($urandom_range(0, 3))
            0: add_byte(b64_pick());
            1: begin
                add_byte(CH_QUOTE);
                repeat ($urandom_range(0, 2)) add_byte(8'($urandom_range(0, 255)));
            end
            2: add_byte(CH_LF);
            default: add_byte(CH_CR);
        endcase
    endtask

    task automatic break_value();
        int k;
        k = $urandom_range(0, value_bytes.size() - 1);
        case ($urandom_range(0, 3))
            0: value_bytes[k].data_byte = 8'($urandom_range(0, 255));
            1: value_bytes[k].first_byte = 1'b1;
            2: value_bytes.insert(k, make_in(($urandom_range(0, 1) == 0) ? CH_LF : CH_CR));
            default: value_bytes.insert(k, make_in(blank_pick()));
        endcase
    endtask

    task automatic send_value();
        value_bytes[0].first_byte = 1'b1;
        value_bytes[value_bytes.size() - 1].last_byte = 1'b1;
        foreach (value_bytes[i]) begin
            send_word(value_bytes[i].data_byte, value_bytes[i].first_byte,
                      value_bytes[i].last_byte);
        end
    endtask

    task automatic test_alphabet();
        send_word(CH_QUOTE, 1'b1, 1'b0);
        send_word("A", 1'b0, 1'b0);
        send_word("z", 1'b0, 1'b0);
        send_word("0", 1'b0, 1'b0);
        send_word(CH_PLUS, 1'b0, 1'b0);
        send_word(CH_SLASH, 1'b0, 1'b0);
        send_word(CH_EQUAL, 1'b0, 1'b0);
        send_word(CH_QUOTE, 1'b0, 1'b0);
    endtask

    task automatic test_folds();
        send_word("Q", 1'b1, 1'b0);
        send_word(CH_LF, 1'b0, 1'b0);
        send_word(CH_SPACE, 1'b0, 1'b0);
        send_word(CH_TAB, 1'b0, 1'b0);
        send_word("r", 1'b0, 1'b0);
        send_word(CH_CR, 1'b0, 1'b0);
        send_word(CH_LF, 1'b0, 1'b0);
        send_word(CH_TAB, 1'b0, 1'b0);
        send_word("9", 1'b0, 1'b1);
    endtask

    task automatic test_ends_and_errors();
        send_word("x", 1'b1, 1'b0);
        send_word(CH_LF, 1'b0, 1'b1);
        send_word("x", 1'b1, 1'b0);
        send_word(CH_CR, 1'b0, 1'b0);
        send_word(CH_LF, 1'b0, 1'b1);
        send_word(CH_SPACE, 1'b1, 1'b0);
        send_word("y", 1'b0, 1'b0);
        send_word("Z", 1'b1, 1'b1);
        send_word(CH_QUOTE, 1'b1, 1'b1);
        send_word("A", 1'b1, 1'b0);
        send_word("B", 1'b1, 1'b0);
        send_word(8'hFF, 1'b0, 1'b1);
        send_word(8'h00, 1'b0, 1'b0);
    endtask

    task automatic test_long_value();
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
        send_word(b64_pick(), 1'b1, 1'b0);
        repeat (LONG_VALUE_LEN) send_word(b64_pick(), 1'b0, 1'b0);
        send_word(b64_pick(), 1'b0, 1'b1);
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
    endtask

    task automatic test_random_values();
        int start_items;
        int pick;
        start_items = live_items;
        while (live_items - start_items < RANDOM_ITEMS) begin
            if ($urandom_range(0, 15) == 0) begin
                tx_idle_on = !tx_idle_on;
            end
            if ($urandom_range(0, 15) == 0) begin
                rx_idle_on = !rx_idle_on;
            end
            pick = $urandom_range(0, 99);
            if (pick < 8) begin
                repeat ($urandom_range(1, 4)) begin
                    send_word(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0,
                              $urandom_range(0, 1) == 1);
                end
            end else begin
                build_value();
                if (pick < 20) begin
                    break_value();
                end
                send_value();
            end
        end
    endtask

    always @(posedge aclk) begin : result_side
        value_word_t want;
        int gap_len;
        if (aresetn && m_valid && m_ready) begin
            if (expected_words.size() == 0) begin
                report_mismatch($sformatf("result word with none expected: kind %0d char %02h",
                                          m_kind, m_hash_char));
            end else begin
                want = expected_words.pop_front();
                if (m_kind !== want.kind) begin
                    report_mismatch($sformatf("kind: got %0d, expected %0d",
                                              m_kind, want.kind));
                end
                if (m_hash_char !== want.hash_char) begin
                    report_mismatch($sformatf("hash_char: got %02h, expected %02h",
                                              m_hash_char, want.hash_char));
                end
                if (m_status !== want.status) begin
                    report_mismatch($sformatf("status: got %0d, expected %0d",
                                              m_status, want.status));
                end
                if (m_hash_length !== want.hash_length) begin
                    report_mismatch($sformatf("hash_length: got %0d, expected %0d",
                                              m_hash_length, want.hash_length));
                end
            end
        end
        if (stall_left > 0) begin
            stall_left = stall_left - 1;
            m_ready <= 1'b0;
        end else begin
            gap_len = pick_gap(rx_idle_on);
            if (gap_len > 0) begin
                stall_left = gap_len - 1;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("** base64_value_unfold_checker: FAILED **");
            $finish;
        end
    end

    initial begin
        unfold_mode = MODE_IDLE;
        kept_len = '0;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        test_alphabet();
        test_folds();
        test_ends_and_errors();
        test_long_value();
        test_random_values();
        s_valid <= 1'b0;
        while (expected_words.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (error_count == 0) begin
            $display("** base64_value_unfold_checker: PASSED **");
        end else begin
            $display("** base64_value_unfold_checker: FAILED **");
        end
        $finish;
    end

endmodule

[filelist.f]
hw/rtl/b64uf_pkg.sv
hw/rtl/b64uf_in_stage.sv
hw/rtl/b64uf_step.sv
hw/rtl/base64_value_unfold_checker.sv
bench/tb_top.sv
